// File: design/hsv_to_rgb_converter_top_defines.svh
// Assertion macros for the HSV to RGB converter.
// Used by hsv_to_rgb_converter_top; expects aclk and aresetn in scope.
`ifndef HSV_TO_RGB_CONVERTER_TOP_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_TOP_DEFINES_SVH

// Condition must hold on the same edge as the trigger
`define HSV_ASSERT_IMPL(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error(msg);

// Condition must hold on the edge after the trigger
`define HSV_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: design/hsv2rgb_pkg.sv
// Shared constants and types for the HSV to RGB converter.
// No dependencies; used by hsv_to_rgb_converter_top.
package hsv2rgb_pkg;

    // Field widths
    localparam int unsigned HUE_W  = 16;
    localparam int unsigned CHAN_W = 9;
    localparam int unsigned REM_W  = 10;
    localparam int unsigned QUO_W  = 7;

    // Fixed point constants
    localparam logic [CHAN_W-1:0] UNIT       = 9'd256;
    localparam logic [REM_W-1:0]  HUE_SECTOR = 10'd960;
    // offset that lifts (hue + 32768) to a multiple of the full turn
    localparam logic [16:0]       HUE_LIFT   = 17'd1792;
    // floor(x/960) estimate: (x * 4370) >> 22, may overshoot by one
    localparam logic [12:0]       RECIP_SECTOR = 13'd4370;
    // floor(y/15) exact for y <= 3840: (y * 4370) >> 16
    localparam logic [12:0]       RECIP_FIFTEEN = 13'd4370;
    // floor(q/6) exact for q <= 70: (q * 43) >> 8
    localparam logic [5:0]        RECIP_SIX = 6'd43;

    localparam int unsigned NUM_STAGES = 6;

    // Hue sector, 60 degrees each
    typedef enum logic [2:0] {
        SECTOR_RED_YELLOW    = 3'd0,
        SECTOR_YELLOW_GREEN  = 3'd1,
        SECTOR_GREEN_CYAN    = 3'd2,
        SECTOR_CYAN_BLUE     = 3'd3,
        SECTOR_BLUE_MAGENTA  = 3'd4,
        SECTOR_MAGENTA_RED   = 3'd5
    } sector_t;

    // Saturate a 9-bit unit value to 256
    function automatic logic [CHAN_W-1:0] clamp_unit(input logic [CHAN_W-1:0] x);
        clamp_unit = (x > UNIT) ? UNIT : x;
    endfunction

endpackage

// File: design/hsv_to_rgb_converter_top.sv
// HSV to RGB converter, six-stage pipeline with per-stage valid bits.
// Depends on hsv2rgb_pkg and hsv_to_rgb_converter_top_defines.svh.
//
// Converts one color per item at one item per clock while m_tready is high.
// m_tvalid rises once the item has passed the six registers that hold it in turn.
// The depth comes from the multiplier chain: hue split by a reciprocal multiply,
// quotient correction, saturation products, divide by 960 through a second
// reciprocal multiply, value products, and the sector mux into the output
// register. Each stage advances whenever the stage after it can take its item, so
// bubbles collapse; input is taken during an output stall if any stage is empty.
`include "hsv_to_rgb_converter_top_defines.svh"

module hsv_to_rgb_converter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // hue[15:0], saturation[24:16], brightness[33:25]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // red[8:0], green[17:9], blue[26:18]
);

    localparam int unsigned NS = hsv2rgb_pkg::NUM_STAGES;
    localparam int unsigned CW = hsv2rgb_pkg::CHAN_W;

    // Input fields
    logic [hsv2rgb_pkg::HUE_W-1:0] hue;
    logic [CW-1:0]                 saturation;
    logic [CW-1:0]                 brightness;

    assign hue        = s_tdata[15:0];
    assign saturation = s_tdata[24:16];
    assign brightness = s_tdata[33:25];

    // Stage control
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 1: clamp, lift hue to non-negative, reciprocal product for hue/960
    logic [16:0]   st1_u_next;
    logic [16:0]   st1_u_reg;
    logic [28:0]   st1_prod_next;
    logic [28:0]   st1_prod_reg;
    logic [CW-1:0] st1_s_reg;
    logic [CW-1:0] st1_v_reg;

    always_comb begin
        st1_u_next    = {1'b0, ~hue[15], hue[14:0]} + hsv2rgb_pkg::HUE_LIFT;
        st1_prod_next = 29'(st1_u_next) * 29'(hsv2rgb_pkg::RECIP_SECTOR);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            st1_u_reg    <= st1_u_next;
            st1_prod_reg <= st1_prod_next;
            st1_s_reg    <= hsv2rgb_pkg::clamp_unit(saturation);
            st1_v_reg    <= hsv2rgb_pkg::clamp_unit(brightness);
        end
    end

    // Stage 2: correct the quotient estimate, form remainder mod 960
    logic [6:0]    st2_q0;
    logic [16:0]   st2_q960;
    logic [17:0]   st2_rem0;
    logic [6:0]    st2_quo_next;
    logic [9:0]    st2_rem_next;
    logic [6:0]    st2_quo_reg;
    logic [9:0]    st2_rem_reg;
    logic [CW-1:0] st2_s_reg;
    logic [CW-1:0] st2_v_reg;

    always_comb begin
        st2_q0   = st1_prod_reg[28:22];
        st2_q960 = {st2_q0, 10'b0} - {4'b0, st2_q0, 6'b0};
        st2_rem0 = {1'b0, st1_u_reg} - {1'b0, st2_q960};
        if (st2_rem0[17]) begin
            // estimate was one too high
            st2_quo_next = st2_q0 - 7'd1;
            st2_rem_next = st2_rem0[9:0] + hsv2rgb_pkg::HUE_SECTOR;
        end else begin
            st2_quo_next = st2_q0;
            st2_rem_next = st2_rem0[9:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            st2_quo_reg <= st2_quo_next;
            st2_rem_reg <= st2_rem_next;
            st2_s_reg   <= st1_s_reg;
            st2_v_reg   <= st1_v_reg;
        end
    end

    // Stage 3: sector = quotient mod 6, saturation products
    logic [12:0]              st3_d6_prod;
    logic [3:0]               st3_d6;
    logic [6:0]               st3_sec_raw;
    logic [9:0]               st3_rem_inv;
    logic [17:0]              st3_sr_next;
    logic [17:0]              st3_sn_next;
    logic [16:0]              st3_pp_next;
    logic [17:0]              st3_sr_reg;
    logic [17:0]              st3_sn_reg;
    logic [16:0]              st3_pp_reg;
    hsv2rgb_pkg::sector_t     st3_sector_reg;
    logic [CW-1:0]            st3_v_reg;

    always_comb begin
        st3_d6_prod = 13'(st2_quo_reg) * 13'(hsv2rgb_pkg::RECIP_SIX);
        st3_d6      = st3_d6_prod[11:8];
        st3_sec_raw = st2_quo_reg - ({3'b0, st3_d6} << 2) - ({3'b0, st3_d6} << 1);
        st3_rem_inv = hsv2rgb_pkg::HUE_SECTOR - st2_rem_reg;
        st3_sr_next = 18'(st2_s_reg) * 18'(st2_rem_reg);
        st3_sn_next = 18'(st2_s_reg) * 18'(st3_rem_inv);
        st3_pp_next = 17'(st2_v_reg) * 17'(hsv2rgb_pkg::UNIT - st2_s_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            st3_sr_reg     <= st3_sr_next;
            st3_sn_reg     <= st3_sn_next;
            st3_pp_reg     <= st3_pp_next;
            st3_sector_reg <= hsv2rgb_pkg::sector_t'(st3_sec_raw[2:0]);
            st3_v_reg      <= st2_v_reg;
        end
    end

    // Stage 4: divide products by 960 as (x >> 6) / 15, form q and t factors
    logic [24:0]          st4_qa_prod;
    logic [24:0]          st4_ta_prod;
    logic [CW-1:0]        st4_qfac_reg;
    logic [CW-1:0]        st4_tfac_reg;
    logic [CW-1:0]        st4_p_reg;
    hsv2rgb_pkg::sector_t st4_sector_reg;
    logic [CW-1:0]        st4_v_reg;

    always_comb begin
        st4_qa_prod = 25'(st3_sr_reg[17:6]) * 25'(hsv2rgb_pkg::RECIP_FIFTEEN);
        st4_ta_prod = 25'(st3_sn_reg[17:6]) * 25'(hsv2rgb_pkg::RECIP_FIFTEEN);
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            st4_qfac_reg   <= hsv2rgb_pkg::UNIT - st4_qa_prod[24:16];
            st4_tfac_reg   <= hsv2rgb_pkg::UNIT - st4_ta_prod[24:16];
            st4_p_reg      <= st3_pp_reg[16:8];
            st4_sector_reg <= st3_sector_reg;
            st4_v_reg      <= st3_v_reg;
        end
    end

    // Stage 5: scale factors by value
    logic [16:0]          st5_qv;
    logic [16:0]          st5_tv;
    logic [CW-1:0]        st5_q_reg;
    logic [CW-1:0]        st5_t_reg;
    logic [CW-1:0]        st5_p_reg;
    hsv2rgb_pkg::sector_t st5_sector_reg;
    logic [CW-1:0]        st5_v_reg;

    always_comb begin
        st5_qv = 17'(st4_v_reg) * 17'(st4_qfac_reg);
        st5_tv = 17'(st4_v_reg) * 17'(st4_tfac_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            st5_q_reg      <= st5_qv[16:8];
            st5_t_reg      <= st5_tv[16:8];
            st5_p_reg      <= st4_p_reg;
            st5_sector_reg <= st4_sector_reg;
            st5_v_reg      <= st4_v_reg;
        end
    end

    // Stage 6: sector mux into the output register
    logic [CW-1:0] red_next;
    logic [CW-1:0] green_next;
    logic [CW-1:0] blue_next;
    logic [CW-1:0] red_reg;
    logic [CW-1:0] green_reg;
    logic [CW-1:0] blue_reg;

    always_comb begin
        case (st5_sector_reg)
            hsv2rgb_pkg::SECTOR_RED_YELLOW: begin
                red_next = st5_v_reg; green_next = st5_t_reg; blue_next = st5_p_reg;
            end
            hsv2rgb_pkg::SECTOR_YELLOW_GREEN: begin
                red_next = st5_q_reg; green_next = st5_v_reg; blue_next = st5_p_reg;
            end
            hsv2rgb_pkg::SECTOR_GREEN_CYAN: begin
                red_next = st5_p_reg; green_next = st5_v_reg; blue_next = st5_t_reg;
            end
            hsv2rgb_pkg::SECTOR_CYAN_BLUE: begin
                red_next = st5_p_reg; green_next = st5_q_reg; blue_next = st5_v_reg;
            end
            hsv2rgb_pkg::SECTOR_BLUE_MAGENTA: begin
                red_next = st5_t_reg; green_next = st5_p_reg; blue_next = st5_v_reg;
            end
            default: begin
                red_next = st5_v_reg; green_next = st5_p_reg; blue_next = st5_q_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = {5'b0, blue_reg, green_reg, red_reg};

    // Terms for the checks
    logic rem_ok;
    logic fac_ok;
    logic chan_ok;

    assign rem_ok  = st2_rem_reg < hsv2rgb_pkg::HUE_SECTOR;
    assign fac_ok  = ({1'b0, st4_qfac_reg} + {1'b0, st4_tfac_reg}) >=
                     {1'b0, hsv2rgb_pkg::UNIT};
    assign chan_ok = (red_reg <= hsv2rgb_pkg::UNIT) && (green_reg <= hsv2rgb_pkg::UNIT) &&
                     (blue_reg <= hsv2rgb_pkg::UNIT);

    // Checks
    `HSV_ASSERT_IMPL(a_rem_range, vld_reg[1], rem_ok, "hue remainder out of range")
    `HSV_ASSERT_IMPL(a_fac_sum, vld_reg[3], fac_ok, "q and t factors inconsistent")
    `HSV_ASSERT_IMPL(a_chan_range, m_tvalid, chan_ok, "output channel above unit")
    `HSV_ASSERT_NEXT(a_take_in, s_tvalid && s_tready, vld_reg[0], "accepted item missing")

endmodule
